@@ sv/fevd_pkg.sv @@
// Package: widths, constants, register map and shared types of the frame energy detector.
`default_nettype none
package fevd_pkg;

	// Sample and frame geometry (frame length is a power of two)
	localparam int SAMPLE_BITS   = 16;
	localparam int FRAME_SAMPLES = 1024;
	localparam int FRAME_LOG2    = $clog2(FRAME_SAMPLES);
	localparam int IDX_W         = FRAME_LOG2;
	localparam int SQ_W          = 2 * SAMPLE_BITS;
	localparam int SUM_W         = 2 * SAMPLE_BITS - 1 + FRAME_LOG2;
	localparam int MEAN_W        = SUM_W - FRAME_LOG2;

	// Square root unit
	localparam int RAD_W      = 32;
	localparam int ROOT_W     = 16;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);

	// Shared multiplier
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Threshold and counters
	localparam int THR_W  = 32;
	localparam int CNT_W  = 16;
	localparam int CFG_W  = 16;
	localparam logic [THR_W-1:0]   THR_RESET = 32'd1610613;
	localparam logic [MUL_B_W-1:0] W_KEEP    = 16'd64881;
	localparam logic [MUL_B_W-1:0] W_GAIN    = 16'd164;
	localparam logic [CNT_W-1:0]   NEVER     = 16'hFFFF;

	// APB register map
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_MIN_TALK = 2'd0;
	localparam logic [1:0] REG_MIN_SIL  = 2'd1;
	localparam logic [1:0] REG_MAX_SIL  = 2'd2;

	localparam logic [CFG_W-1:0] MIN_TALK_RESET = 16'd8;
	localparam logic [CFG_W-1:0] MIN_SIL_RESET  = 16'd65;
	localparam logic [CFG_W-1:0] MAX_SIL_RESET  = 16'd431;

	typedef struct packed {
		logic [CFG_W-1:0] min_talk_frames;
		logic [CFG_W-1:0] min_silence_frames;
		logic [CFG_W-1:0] max_silence_frames;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/fevd_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
`default_nettype none
module fevd_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [fevd_pkg::RAD_W-1:0] radicand,
	output logic                            done,
	output logic [fevd_pkg::ROOT_W-1:0]     root
);
	import fevd_pkg::*;

	logic [RAD_W-1:0]  v_q;
	logic [RAD_W-1:0]  res_q;
	logic [RAD_W-1:0]  bit_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RAD_W-1:0]  trial;

	assign trial = res_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule
`default_nettype wire

@@ sv/fevd_mul.sv @@
// Shared 32x16 unsigned multiplier with a registered product.
`default_nettype none
module fevd_mul (
	input  wire logic                         clk,
	input  wire logic [fevd_pkg::MUL_A_W-1:0] a,
	input  wire logic [fevd_pkg::MUL_B_W-1:0] b,
	output logic [fevd_pkg::PROD_W-1:0]       prod_q
);
	import fevd_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule
`default_nettype wire

@@ sv/fevd_regs.sv @@
// APB configuration registers: talk and silence frame limits.
`default_nettype none
module fevd_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [fevd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [fevd_pkg::PDATA_W-1:0] pwdata,
	output logic [fevd_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	output fevd_pkg::cfg_t                    cfg
);
	import fevd_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr;

	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register write; addresses past the map are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_talk_frames    <= MIN_TALK_RESET;
			cfg_q.min_silence_frames <= MIN_SIL_RESET;
			cfg_q.max_silence_frames <= MAX_SIL_RESET;
		end else if (wr) begin
			case (idx)
				REG_MIN_TALK: cfg_q.min_talk_frames    <= pwdata[CFG_W-1:0];
				REG_MIN_SIL:  cfg_q.min_silence_frames <= pwdata[CFG_W-1:0];
				REG_MAX_SIL:  cfg_q.max_silence_frames <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_MIN_TALK: prdata = PDATA_W'(cfg_q.min_talk_frames);
			REG_MIN_SIL:  prdata = PDATA_W'(cfg_q.min_silence_frames);
			REG_MAX_SIL:  prdata = PDATA_W'(cfg_q.max_silence_frames);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ sv/frame_energy_voice_detector_top.sv @@
// Top level: frame energy voice activity detector with sequencer and datapath.
//
// Input channel (in_valid/in_ready, sample): one signed 16-bit audio sample per beat.
// Output channel (out_valid/out_ready): one result beat per finished frame of
// 1024 samples, carrying talking, segment_done, intensity (RMS of the frame),
// level_threshold (adapted Q16.16 threshold) and talk_count.
// Configuration: APB port, three 16-bit registers at 0x0, 0x4, 0x8
// (min_talk_frames, min_silence_frames, max_silence_frames); write only while idle.
// Sequence: a sample that does not end a frame is accepted, squared on the
// shared multiplier and accumulated. After the last sample of a frame is
// accumulated, the sequencer starts the square root unit and waits on it (16
// two-bit steps plus its done strobe), then runs the threshold compare, two
// passes through the shared multiplier, the threshold sum and loading the
// result beat; only then is the next sample accepted.
// in_ready is high only while the sequencer is idle.
// Reset clears the energy sum and sample count, resets the counters and loads the
// threshold with its initial value; the registers take their default limits.
// A stalled receiver keeps the result beat held; the block keeps accepting
// samples, and only waits at the end of the next frame if that beat is still held.
`default_nettype none
module frame_energy_voice_detector_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [fevd_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     talking,
	output logic                                     segment_done,
	output logic [fevd_pkg::ROOT_W-1:0]              intensity,
	output logic [fevd_pkg::THR_W-1:0]               level_threshold,
	output logic [fevd_pkg::CNT_W-1:0]               talk_count,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [fevd_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [fevd_pkg::PDATA_W-1:0]        pwdata,
	output logic [fevd_pkg::PDATA_W-1:0]             prdata,
	output logic                                     pready
);
	import fevd_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SQ      = 4'd1;
	localparam logic [3:0] S_ACC     = 4'd2;
	localparam logic [3:0] S_ROOT_GO = 4'd3;
	localparam logic [3:0] S_ROOT    = 4'd4;
	localparam logic [3:0] S_CMP     = 4'd5;
	localparam logic [3:0] S_MUL1    = 4'd6;
	localparam logic [3:0] S_MUL2    = 4'd7;
	localparam logic [3:0] S_SUM     = 4'd8;
	localparam logic [3:0] S_OUT     = 4'd9;

	cfg_t                   cfg;
	logic [3:0]             state_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [SUM_W-1:0]       sum_q;
	logic [IDX_W-1:0]       idx_q;
	logic [ROOT_W-1:0]      int_q;
	logic [THR_W-1:0]       thr_q;
	logic [THR_W-1:0]       thr_adj_q;
	logic [THR_W-1:0]       keep_q;
	logic                   was_talking_q;
	logic                   talking_q;
	logic                   done_q;
	logic [CNT_W-1:0]       talk_frames_q;
	logic [CNT_W-1:0]       since_talk_q;
	logic                   out_valid_q;
	logic                   out_talking_q;
	logic                   out_done_q;
	logic [ROOT_W-1:0]      out_int_q;
	logic [THR_W-1:0]       out_thr_q;
	logic [CNT_W-1:0]       out_count_q;

	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic [PROD_W-1:0]      prod;
	logic                   root_start;
	logic                   root_done;
	logic [ROOT_W-1:0]      root;
	logic                   is_talk;
	logic [THR_W:0]         upd;
	logic                   seg_hit;
	logic                   slot_free;

	fevd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fevd_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	fevd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (RAD_W'(sum_q[SUM_W-1:FRAME_LOG2])),
		.done     (root_done),
		.root     (root)
	);

	// multiplier operand select
	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = MUL_B_W'(mag_q);
			end
			S_MUL1: begin
				mul_a = thr_adj_q;
				mul_b = W_KEEP;
			end
			S_MUL2: begin
				mul_a = MUL_A_W'(int_q);
				mul_b = W_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign root_start = (state_q == S_ROOT_GO);
	assign is_talk    = {int_q, 16'h0000} > thr_q;
	assign upd        = {1'b0, keep_q} + (THR_W + 1)'(prod[SQ_W-1:0]);
	assign seg_hit    = !talking_q
		&& (since_talk_q >= cfg.min_silence_frames)
		&& (since_talk_q <= cfg.max_silence_frames)
		&& (talk_frames_q >= cfg.min_talk_frames)
		&& (talk_frames_q != '0);
	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sum_q         <= '0;
			idx_q         <= '0;
			thr_q         <= THR_RESET;
			was_talking_q <= 1'b0;
			talk_frames_q <= '0;
			since_talk_q  <= NEVER;
			out_valid_q   <= 1'b0;
		end else begin
			// result beat: raised when loaded, dropped once taken
			if (state_q == S_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q <= sum_q + SUM_W'(prod[SQ_W-1:0]);
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(FRAME_SAMPLES - 1))
						state_q <= S_ROOT_GO;
					else
						state_q <= S_IDLE;
				end
				S_ROOT_GO: begin
					sum_q   <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done)
						state_q <= S_CMP;
				end
				S_CMP: begin
					was_talking_q <= is_talk;
					if (is_talk) begin
						if (talk_frames_q != NEVER)
							talk_frames_q <= talk_frames_q + CNT_W'(1);
						since_talk_q <= '0;
					end else if (since_talk_q != NEVER) begin
						since_talk_q <= since_talk_q + CNT_W'(1);
					end
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					thr_q <= upd[THR_W] ? {THR_W{1'b1}} : upd[THR_W-1:0];
					if (seg_hit) begin
						talk_frames_q <= '0;
						since_talk_q  <= NEVER;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid)
			mag_q <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1) : sample;
		if (state_q == S_ROOT && root_done)
			int_q <= root;
		if (state_q == S_CMP) begin
			talking_q <= is_talk;
			done_q    <= 1'b0;
			if (is_talk && !was_talking_q)
				thr_adj_q <= thr_q >> 2;
			else if (!is_talk && was_talking_q)
				thr_adj_q <= (thr_q[THR_W-1:THR_W-2] != 2'b00) ? {THR_W{1'b1}} : (thr_q << 2);
			else
				thr_adj_q <= thr_q;
		end
		if (state_q == S_MUL2)
			keep_q <= prod[PROD_W-1:MUL_B_W];
		if (state_q == S_SUM)
			done_q <= seg_hit;
		if (state_q == S_OUT && slot_free) begin
			out_talking_q <= talking_q;
			out_done_q    <= done_q;
			out_int_q     <= int_q;
			out_thr_q     <= thr_q;
			out_count_q   <= talk_frames_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign talking         = out_talking_q;
	assign segment_done    = out_done_q;
	assign intensity       = out_int_q;
	assign level_threshold = out_thr_q;
	assign talk_count      = out_count_q;

endmodule
`default_nettype wire

@@ sv/fevd_checker.sv @@
// Port-level checker for the frame energy detector, bound to the top level.
`default_nettype none
module fevd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        talking,
	input wire logic        segment_done,
	input wire logic [31:0] level_threshold,
	input wire logic [15:0] talk_count
);

	// a held result beat stays up with the same threshold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_threshold))
		else $error("result beat dropped or changed while stalled");

	// a completed segment resets the talk count and is a silent frame
	a_seg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_done |-> talk_count == 16'd0 && !talking)
		else $error("segment done with nonzero talk count or talking");

	// a talking frame is always counted
	a_talk_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && talking |-> talk_count != 16'd0)
		else $error("talking frame with zero talk count");

	// one sample at a time: ready drops after each accepted beat
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready held after accepted beat");

endmodule

bind frame_energy_voice_detector_top fevd_checker u_fevd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.talking         (talking),
	.segment_done    (segment_done),
	.level_threshold (level_threshold),
	.talk_count      (talk_count)
);
`default_nettype wire
